// ===== src/acalc_pkg.sv =====
// ----------------------------------------------------------------------------
// ASCII expression calculator package
// Character codes, result status codes and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package acalc_pkg;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_STAR  = 8'd42;
  localparam logic [7:0] CH_SLASH = 8'd47;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_OP     = 2'd1,
    ST_DIV_ZERO   = 2'd2,
    ST_INCOMPLETE = 2'd3
  } status_e;

  typedef struct packed {
    logic take_byte;
    logic acc_a;
    logic acc_b;
    logic set_op;
    logic eval;
    logic incomplete;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_digit;
    logic is_colon;
    logic div_go;
    logic div_done;
  } dp_sts_t;

endpackage

// ===== src/ascii_expression_calculator_top.sv =====
// ----------------------------------------------------------------------------
// ASCII expression calculator
// Parses messages of the form name:A op B one byte per beat and returns the
// client id with the signed 32-bit result and a status code per message.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  in      | to block  | in_valid / in_stall  | msg_byte, end_of_message, client_id
//  out     | from block| out_valid / out_stall| client_ref, answer, status
//
//  A byte that does not end a message is taken without stalling the input.
//  After a final byte the input stalls through evaluation and the output load;
//  a quotient also waits for the divider, which makes one quotient bit per cycle.
//  Reset clears the parse phase, operands and operator; there is no sweep.
//  The output register holds one result, so parsing of the next message goes
//  on while it waits; a stalled output holds the input only after a final byte.
// ----------------------------------------------------------------------------
module ascii_expression_calculator_top
  import acalc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         in_msg_byte_i,
  input  logic               in_end_of_message_i,
  input  logic [30:0]        in_client_id_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [30:0]        out_client_ref_o,
  output logic signed [31:0] out_answer_o,
  output logic [1:0]         out_status_o
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  acalc_ctrl u_ctrl (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_end_of_message_i (in_end_of_message_i),
    .out_stall_i         (out_stall_i),
    .sts_i               (sts),
    .cmd_o               (cmd),
    .in_stall_o          (in_stall_o),
    .out_valid_o         (out_valid_o)
  );

  acalc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .msg_byte_i   (in_msg_byte_i),
    .client_id_i  (in_client_id_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .client_ref_o (out_client_ref_o),
    .answer_o     (out_answer_o),
    .status_o     (out_status_o)
  );

`ifndef SYNTH
  a_final_beat_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_end_of_message_i) |=> in_stall_o)
    else $error("Input not blocked after the final beat of a message.");

  a_result_follows_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (in_stall_o && (!out_valid_o || !out_stall_i)))
    else $error("Result loaded while parsing or over a pending result.");

  a_error_answer_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_status_o != ST_OK)) |-> (out_answer_o == 32'sd0))
    else $error("Nonzero answer delivered with an error status.");
`endif

endmodule

// ===== src/acalc_div.sv =====
// ----------------------------------------------------------------------------
// Signed divider
// Restoring radix-2 divider on operand magnitudes, one quotient bit per
// cycle, with the sign applied to the truncated quotient at the end.
// ----------------------------------------------------------------------------
module acalc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] dvs_q, dvs_d;
  logic        neg_q, neg_d;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem_q, quo_q[31]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i[31] ? (32'd0 - dividend_i) : dividend_i;
      dvs_d  = divisor_i[31] ? (32'd0 - divisor_i) : divisor_i;
      neg_d  = dividend_i[31] ^ divisor_i[31];
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_d = diff[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted[31:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (32'd0 - quo_q) : quo_q;

endmodule

// ===== src/acalc_dp.sv =====
// ----------------------------------------------------------------------------
// Calculator datapath
// Operand accumulators, operator register, result evaluation with the
// multiplier and divider, and the output payload registers.
// ----------------------------------------------------------------------------
module acalc_dp
  import acalc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         msg_byte_i,
  input  logic [30:0]        client_id_i,
  input  ctrl_cmd_t          cmd_i,
  output dp_sts_t            sts_o,
  output logic [30:0]        client_ref_o,
  output logic signed [31:0] answer_o,
  output logic [1:0]         status_o
);

  logic [31:0] a_q, a_d;
  logic [31:0] b_q, b_d;
  logic [7:0]  op_q, op_d;
  logic [30:0] id_q;
  logic [31:0] res_q, res_d;
  status_e     st_q, st_d;
  logic [30:0] out_id_q;
  logic [31:0] out_res_q;
  status_e     out_st_q;
  logic [31:0] a_acc;
  logic [31:0] b_acc;
  logic        div_go;
  logic        div_done;
  logic [31:0] quotient;

  assign a_acc = {a_q[28:0], 3'b000} + {a_q[30:0], 1'b0} + {24'd0, msg_byte_i} - 32'd48;
  assign b_acc = {b_q[28:0], 3'b000} + {b_q[30:0], 1'b0} + {24'd0, msg_byte_i} - 32'd48;

  assign div_go = !cmd_i.incomplete && (op_q == CH_SLASH) && (b_q != 32'd0);

  assign sts_o.is_digit = (msg_byte_i >= CH_ZERO) && (msg_byte_i <= CH_NINE);
  assign sts_o.is_colon = (msg_byte_i == CH_COLON);
  assign sts_o.div_go   = div_go;
  assign sts_o.div_done = div_done;

  acalc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.eval && div_go),
    .dividend_i (a_q),
    .divisor_i  (b_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    a_d  = a_q;
    b_d  = b_q;
    op_d = op_q;
    if (cmd_i.out_load) begin
      a_d  = '0;
      b_d  = '0;
      op_d = '0;
    end else begin
      if (cmd_i.acc_a) begin
        a_d = a_acc;
      end
      if (cmd_i.acc_b) begin
        b_d = b_acc;
      end
      if (cmd_i.set_op) begin
        op_d = msg_byte_i;
      end
    end
  end

  always_comb begin
    res_d = res_q;
    st_d  = st_q;
    if (cmd_i.eval) begin
      res_d = '0;
      st_d  = ST_OK;
      priority if (cmd_i.incomplete) begin
        st_d = ST_INCOMPLETE;
      end else if (op_q == CH_PLUS) begin
        res_d = a_q + b_q;
      end else if (op_q == CH_MINUS) begin
        res_d = a_q - b_q;
      end else if (op_q == CH_STAR) begin
        res_d = a_q * b_q;
      end else if (op_q == CH_SLASH) begin
        if (b_q == 32'd0) begin
          st_d = ST_DIV_ZERO;
        end
      end else begin
        st_d = ST_BAD_OP;
      end
    end else if (div_done) begin
      res_d = quotient;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q  <= '0;
      b_q  <= '0;
      op_q <= '0;
    end else begin
      a_q  <= a_d;
      b_q  <= b_d;
      op_q <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    st_q  <= st_d;
    if (cmd_i.take_byte) begin
      id_q <= client_id_i;
    end
    if (cmd_i.out_load) begin
      out_id_q  <= id_q;
      out_res_q <= res_q;
      out_st_q  <= st_q;
    end
  end

  assign client_ref_o = out_id_q;
  assign answer_o     = out_res_q;
  assign status_o     = out_st_q;

endmodule

// ===== src/acalc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Calculator controller
// Tracks the parse phase of the message, sequences evaluation at the final
// beat, and owns both handshakes.
// ----------------------------------------------------------------------------
module acalc_ctrl
  import acalc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_end_of_message_i,
  input  logic      out_stall_i,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o,
  output logic      in_stall_o,
  output logic      out_valid_o
);

  typedef enum logic [3:0] {
    C_RUN  = 4'b0001,
    C_EVAL = 4'b0010,
    C_DIV  = 4'b0100,
    C_DONE = 4'b1000
  } ctrl_state_e;

  typedef enum logic [4:0] {
    P_NAME   = 5'b00001,
    P_AFIRST = 5'b00010,
    P_ADIG   = 5'b00100,
    P_BDIG   = 5'b01000,
    P_IGNORE = 5'b10000
  } phase_e;

  ctrl_state_e state_q, state_d;
  phase_e      phase_q, phase_d;
  logic        out_valid_q, out_valid_d;
  logic        in_acc;

  assign in_acc = in_valid_i && (state_q == C_RUN);

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      C_RUN: begin
        if (in_acc) begin
          cmd_o.take_byte = 1'b1;
          unique case (phase_q)
            P_NAME: begin
              if (sts_i.is_colon) begin
                phase_d = P_AFIRST;
              end
            end
            P_AFIRST: begin
              cmd_o.acc_a = 1'b1;
              phase_d     = P_ADIG;
            end
            P_ADIG: begin
              if (sts_i.is_digit) begin
                cmd_o.acc_a = 1'b1;
              end else begin
                cmd_o.set_op = 1'b1;
                phase_d      = P_BDIG;
              end
            end
            P_BDIG: begin
              if (sts_i.is_digit) begin
                cmd_o.acc_b = 1'b1;
              end else begin
                phase_d = P_IGNORE;
              end
            end
            P_IGNORE: begin
            end
            default: begin
              phase_d = P_NAME;
            end
          endcase
          if (in_end_of_message_i) begin
            state_d = C_EVAL;
          end
        end
      end
      C_EVAL: begin
        cmd_o.eval       = 1'b1;
        cmd_o.incomplete = (phase_q == P_NAME) || (phase_q == P_AFIRST) ||
                           (phase_q == P_ADIG);
        state_d          = sts_i.div_go ? C_DIV : C_DONE;
      end
      C_DIV: begin
        if (sts_i.div_done) begin
          state_d = C_DONE;
        end
      end
      C_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          phase_d        = P_NAME;
          state_d        = C_RUN;
        end
      end
      default: begin
        state_d = C_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= C_RUN;
      phase_q     <= P_NAME;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != C_RUN);
  assign out_valid_o = out_valid_q;

endmodule

// ===== verif/ascii_expression_calculator_top_tb.sv =====
// ----------------------------------------------------------------------------
// ASCII expression calculator testbench
// Sends messages name:A op B one byte per beat and checks each result beat
// against a cycle-free model of the parser and the arithmetic, or for typed
// directed messages against the table's values. The short directed table comes
// first, then random messages under four idling patterns on both channels.
// ----------------------------------------------------------------------------
module ascii_expression_calculator_top_tb;
  import acalc_pkg::*;

  localparam int BEAT_TARGET    = 1450;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  typedef enum logic [2:0] {
    PARSE_NAME,
    PARSE_A_FIRST,
    PARSE_A,
    PARSE_B,
    PARSE_TAIL
  } parse_e;

  typedef struct {
    logic [30:0] client;
    logic [31:0] answer;
    status_e     status;
  } calc_result_t;

  typedef struct {
    int unsigned len;
    logic [255:0] text;
    logic [30:0]  id;
    bit           typed;
    logic [31:0]  answer;
    status_e      status;
  } directed_msg_t;

  logic               clk_i               = 1'b0;
  logic               rst_ni              = 1'b0;
  logic               in_valid_i          = 1'b0;
  logic               in_stall_o;
  logic [7:0]         in_msg_byte_i       = 8'd0;
  logic               in_end_of_message_i = 1'b0;
  logic [30:0]        in_client_id_i      = 31'd0;
  logic               out_valid_o;
  logic               out_stall_i         = 1'b0;
  logic [30:0]        out_client_ref_o;
  logic signed [31:0] out_answer_o;
  logic [1:0]         out_status_o;

  parse_e      pr_phase = PARSE_NAME;
  logic [31:0] pr_a     = 32'd0;
  logic [31:0] pr_b     = 32'd0;
  logic [7:0]  pr_op    = 8'd0;

  calc_result_t results_due[$];
  int error_count    = 0;
  int beats_used     = 0;
  int idle_cycles    = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  // The byte after ':' counts as a digit even when it is not one; the last
  // message divides the most negative value by minus one.
  directed_msg_t directed_msgs [7] = '{
    '{5,  {8'h00, ":", 8'hFF, "/0"}, 31'h7FFFFFFF, 1'b1, 32'd0, ST_DIV_ZERO},
    '{1,  ":",                       31'h00000000, 1'b1, 32'd0, ST_INCOMPLETE},
    '{5,  "ab:5%",                   31'h2AAAAAAA, 1'b1, 32'd0, ST_BAD_OP},
    '{7,  ":93-4x7",                 31'h55555555, 1'b0, 32'd0, ST_OK},
    '{4,  ":6*7",                    31'h00000003, 1'b0, 32'd0, ST_OK},
    '{3,  ":8+",                     31'h00000004, 1'b0, 32'd0, ST_OK},
    '{21, ":E47483648/4294967295",   31'h00000005, 1'b1, 32'h80000000, ST_OK}
  };

  ascii_expression_calculator_top u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_msg_byte_i       (in_msg_byte_i),
    .in_end_of_message_i (in_end_of_message_i),
    .in_client_id_i      (in_client_id_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_client_ref_o    (out_client_ref_o),
    .out_answer_o        (out_answer_o),
    .out_status_o        (out_status_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit is_digit(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic bit calc_step(input logic [7:0] b, input logic eom,
                                   input logic [30:0] id, output calc_result_t res);
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] quo;
    case (pr_phase)
      PARSE_NAME: begin
        if (b == CH_COLON) pr_phase = PARSE_A_FIRST;
      end
      PARSE_A_FIRST: begin
        pr_a = pr_a * 32'd10 + {24'd0, b} - 32'd48;
        pr_phase = PARSE_A;
      end
      PARSE_A: begin
        if (is_digit(b)) begin
          pr_a = pr_a * 32'd10 + {24'd0, b} - 32'd48;
        end else begin
          pr_op = b;
          pr_phase = PARSE_B;
        end
      end
      PARSE_B: begin
        if (is_digit(b)) pr_b = pr_b * 32'd10 + {24'd0, b} - 32'd48;
        else pr_phase = PARSE_TAIL;
      end
      default: ;
    endcase
    if (!eom) return 1'b0;
    res.client = id;
    res.answer = 32'd0;
    res.status = ST_OK;
    if (pr_phase < PARSE_B) begin
      res.status = ST_INCOMPLETE;
    end else begin
      case (pr_op)
        CH_PLUS:  res.answer = pr_a + pr_b;
        CH_MINUS: res.answer = pr_a - pr_b;
        CH_STAR:  res.answer = pr_a * pr_b;
        CH_SLASH: begin
          if (pr_b == 32'd0) begin
            res.status = ST_DIV_ZERO;
          end else begin
            mag_a = pr_a[31] ? -pr_a : pr_a;
            mag_b = pr_b[31] ? -pr_b : pr_b;
            quo = mag_a / mag_b;
            res.answer = (pr_a[31] ^ pr_b[31]) ? -quo : quo;
          end
        end
        default:  res.status = ST_BAD_OP;
      endcase
    end
    pr_phase = PARSE_NAME;
    pr_a = 32'd0;
    pr_b = 32'd0;
    pr_op = 8'd0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic int operand_len();
    return ($urandom_range(7) == 0) ? $urandom_range(4, 11) : $urandom_range(0, 3);
  endfunction

  task automatic make_request(output logic [7:0] msg[$]);
    logic [7:0] b;
    int n;
    msg = {};
    if ($urandom_range(99) < 75) begin
      repeat ($urandom_range(3)) begin
        b = 8'($urandom_range(255));
        msg.push_back((b == CH_COLON) ? CH_ZERO : b);
      end
      msg.push_back(CH_COLON);
      msg.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : rand_digit());
      repeat (operand_len()) msg.push_back(rand_digit());
      if ($urandom_range(9) == 0) begin
        b = 8'($urandom_range(255));
        if (is_digit(b)) b = b + 8'd10;
      end else begin
        case ($urandom_range(3))
          0:       b = CH_PLUS;
          1:       b = CH_MINUS;
          2:       b = CH_STAR;
          default: b = CH_SLASH;
        endcase
      end
      msg.push_back(b);
      repeat (operand_len()) msg.push_back(rand_digit());
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 4)) msg.push_back(8'($urandom_range(255)));
      end
      if ($urandom_range(9) == 0) begin
        n = $urandom_range(1, msg.size());
        msg = msg[0:n-1];
      end
    end else begin
      repeat ($urandom_range(1, 8)) begin
        msg.push_back(($urandom_range(4) == 0) ? CH_COLON : 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic send_message(input logic [7:0] msg[$], input logic [30:0] id,
                              input bit typed, input calc_result_t typed_res);
    calc_result_t res;
    logic eom;
    for (int k = 0; k < msg.size(); k++) begin
      while ($urandom_range(99) < src_idle_pct) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
      eom = (k == msg.size() - 1);
      in_valid_i <= 1'b1;
      in_msg_byte_i <= msg[k];
      in_end_of_message_i <= eom;
      in_client_id_i <= eom ? id : 31'($urandom);
      do @(posedge clk_i); while (in_stall_o !== 1'b0);
      beats_used++;
      if (calc_step(msg[k], eom, id, res)) results_due.push_back(typed ? typed_res : res);
      @(negedge clk_i);
    end
  endtask

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 50) $display("%0t: mismatch: %s", $time, what);
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < sink_stall_pct);
  end

  always @(posedge clk_i) begin
    calc_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result beat with no message pending, client_ref %h",
                                  out_client_ref_o));
      end else begin
        want = results_due.pop_front();
        if (out_client_ref_o !== want.client)
          report_mismatch($sformatf("client_ref %h, expected %h", out_client_ref_o,
                                    want.client));
        if (out_answer_o !== want.answer)
          report_mismatch($sformatf("answer %h, expected %h (client %h)", out_answer_o,
                                    want.answer, want.client));
        if (out_status_o !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d (client %h)", out_status_o,
                                    want.status, want.client));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("ascii_expression_calculator_top_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] msg[$];
    int src_pct [4]  = '{0, 45, 0, 30};
    int sink_pct [4] = '{0, 0, 45, 30};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed_msgs[i]) begin
      msg = {};
      for (int k = 0; k < directed_msgs[i].len; k++) begin
        msg.push_back(directed_msgs[i].text[8 * (directed_msgs[i].len - 1 - k) +: 8]);
      end
      send_message(msg, directed_msgs[i].id, directed_msgs[i].typed,
                   '{directed_msgs[i].id, directed_msgs[i].answer, directed_msgs[i].status});
    end
    for (int p = 0; p < 4; p++) begin
      src_idle_pct = src_pct[p];
      sink_stall_pct = sink_pct[p];
      while (beats_used < (p + 1) * (BEAT_TARGET / 4)) begin
        make_request(msg);
        send_message(msg, 31'($urandom), 1'b0, '{31'd0, 32'd0, ST_OK});
      end
    end
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ascii_expression_calculator_top_tb: PASS");
    end else begin
      $display("ascii_expression_calculator_top_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/acalc_pkg.sv
src/acalc_div.sv
src/acalc_dp.sv
src/acalc_ctrl.sv
src/ascii_expression_calculator_top.sv
verif/ascii_expression_calculator_top_tb.sv
